// ----- sv/lfsm_pkg.sv -----
`timescale 1ns / 1ps
package lfsm_pkg;

   localparam int MODE_W      = 2;
   localparam int SLOT_W      = 2;
   localparam int FRAME_W     = 64;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 1;
   localparam int REQ_PAD_W   = REQ_TDATA_W - SLOT_W - FRAME_W;
   localparam int RSP_PAD_W   = RSP_TDATA_W - SLOT_W - FRAME_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_BUILD   = 2'd0,
      MODE_PUBLISH = 2'd1,
      MODE_ACQUIRE = 2'd2,
      MODE_RELEASE = 2'd3
   } req_mode_type;

   typedef enum logic [1:0] {
      SLOT_FREE      = 2'd0,
      SLOT_BUILDING  = 2'd1,
      SLOT_PUBLISHED = 2'd2,
      SLOT_READING   = 2'd3
   } slot_state_type;

   typedef enum logic [4:0] {
      CS_IDLE   = 5'b00001,
      CS_SCAN   = 5'b00010,
      CS_DECIDE = 5'b00100,
      CS_UPDATE = 5'b01000,
      CS_HOLD   = 5'b10000
   } ctrl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic latch_req;
      logic scan_en;
      logic decide;
      logic update_en;
      logic load_out;
   } dp_cmd_type;

endpackage

// ----- sv/lfsm_ctrl.sv -----
`timescale 1ns / 1ps
module lfsm_ctrl #(
   parameter int SLOT_COUNT = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output lfsm_pkg::dp_cmd_type   cmd,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] ptr
);
   import lfsm_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   ctrl_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic              valid_ff, valid_in;
   logic              out_free;
   logic              ptr_last;

   assign out_free  = !valid_ff || rsp_ready;
   assign ptr_last  = (ptr_ff == LAST_IDX);
   assign req_ready = (state_ff == CS_IDLE);
   assign rsp_valid = valid_ff;
   assign ptr       = ptr_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      cmd      = '0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               ptr_in        = '0;
               state_in      = CS_SCAN;
            end
         end
         CS_SCAN: begin
            cmd.scan_en = 1'b1;
            if (ptr_last) begin
               ptr_in   = '0;
               state_in = CS_DECIDE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         CS_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = CS_UPDATE;
         end
         CS_UPDATE: begin
            cmd.update_en = 1'b1;
            if (ptr_last) begin
               ptr_in = '0;
               if (out_free) begin
                  cmd.load_out = 1'b1;
                  state_in     = CS_IDLE;
               end else begin
                  state_in = CS_HOLD;
               end
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         CS_HOLD: begin
            // result waits here while the previous beat is still unclaimed
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- sv/lfsm_datapath.sv -----
`timescale 1ns / 1ps
module lfsm_datapath #(
   parameter int SLOT_COUNT = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lfsm_pkg::dp_cmd_type                  cmd,
   input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] ptr,
   input  lfsm_pkg::req_mode_type                req_mode,
   input  logic [lfsm_pkg::SLOT_W-1:0]           req_slot,
   input  logic [lfsm_pkg::FRAME_W-1:0]          req_frame,
   output logic                                  rsp_ok,
   output logic [lfsm_pkg::SLOT_W-1:0]           rsp_slot,
   output logic [lfsm_pkg::FRAME_W-1:0]          rsp_frame
);
   import lfsm_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // request
   req_mode_type          mode_ff, mode_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;

   // slot pool
   slot_state_type        slot_state_ff [SLOT_COUNT];
   slot_state_type        slot_state_in [SLOT_COUNT];
   logic [FRAME_W-1:0]    slot_frame_ff [SLOT_COUNT];
   logic [FRAME_W-1:0]    slot_frame_in [SLOT_COUNT];
   logic                  build_open_ff, build_open_in;
   logic [IDX_W-1:0]      build_slot_ff, build_slot_in;
   logic                  read_open_ff, read_open_in;
   logic [IDX_W-1:0]      read_slot_ff, read_slot_in;

   // scan results
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  pub_found_ff, pub_found_in;
   logic [IDX_W-1:0]      pub_idx_ff, pub_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [FRAME_W-1:0]    best_frame_ff, best_frame_in;
   logic [FRAME_W-1:0]    rd_frame_ff, rd_frame_in;

   // decision
   logic                  dec_ok, dec_ok_ff;
   logic                  dec_act, dec_act_ff;
   logic [IDX_W-1:0]      dec_pick, dec_pick_ff;
   logic [SLOT_W-1:0]     dec_slot, dec_slot_ff;
   logic [FRAME_W-1:0]    dec_frame, dec_frame_ff;

   // result beat
   logic                  out_ok_ff;
   logic [SLOT_W-1:0]     out_slot_ff;
   logic [FRAME_W-1:0]    out_frame_ff;

   slot_state_type        cur_state;
   logic [FRAME_W-1:0]    cur_frame;
   logic                  hit;

   assign cur_state = slot_state_ff[ptr];
   assign cur_frame = slot_frame_ff[ptr];
   assign hit       = (ptr == dec_pick_ff);

   assign rsp_ok    = out_ok_ff;
   assign rsp_slot  = out_slot_ff;
   assign rsp_frame = out_frame_ff;

   // request capture and scan pass
   always_comb begin
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      frame_in      = frame_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      pub_found_in  = pub_found_ff;
      pub_idx_in    = pub_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_frame_in = best_frame_ff;
      rd_frame_in   = rd_frame_ff;
      if (cmd.latch_req) begin
         mode_in       = req_mode;
         idx_in        = req_slot;
         frame_in      = req_frame;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         pub_found_in  = 1'b0;
         pub_idx_in    = '0;
         best_found_in = 1'b0;
         best_idx_in   = '0;
         best_frame_in = '0;
         rd_frame_in   = '0;
      end else if (cmd.scan_en) begin
         if (!free_found_ff && cur_state == SLOT_FREE) begin
            free_found_in = 1'b1;
            free_idx_in   = ptr;
         end
         if (!pub_found_ff && cur_state == SLOT_PUBLISHED) begin
            pub_found_in = 1'b1;
            pub_idx_in   = ptr;
         end
         // strict compare keeps the lowest index on equal frame numbers
         if (cur_state == SLOT_PUBLISHED && (!best_found_ff || cur_frame > best_frame_ff)) begin
            best_found_in = 1'b1;
            best_idx_in   = ptr;
            best_frame_in = cur_frame;
         end
         if (ptr == read_slot_ff) begin
            rd_frame_in = cur_frame;
         end
      end
   end

   // decision from the scan results
   always_comb begin
      dec_ok    = 1'b0;
      dec_act   = 1'b0;
      dec_pick  = '0;
      dec_slot  = '0;
      dec_frame = '0;
      case (mode_ff)
         MODE_BUILD: begin
            dec_ok   = !build_open_ff && (free_found_ff || pub_found_ff);
            dec_act  = dec_ok;
            dec_pick = free_found_ff ? free_idx_ff : pub_idx_ff;
            dec_slot = dec_ok ? SLOT_W'(dec_pick) : '0;
         end
         MODE_PUBLISH: begin
            dec_ok   = build_open_ff && (CMP_W'(build_slot_ff) == CMP_W'(idx_ff));
            dec_act  = dec_ok;
            dec_pick = build_slot_ff;
         end
         MODE_ACQUIRE: begin
            if (read_open_ff) begin
               // slot already out for reading: hand it back unchanged
               dec_ok    = 1'b1;
               dec_slot  = SLOT_W'(read_slot_ff);
               dec_frame = rd_frame_ff;
            end else begin
               dec_ok    = best_found_ff;
               dec_act   = best_found_ff;
               dec_pick  = best_idx_ff;
               dec_slot  = best_found_ff ? SLOT_W'(best_idx_ff) : '0;
               dec_frame = best_found_ff ? best_frame_ff : '0;
            end
         end
         MODE_RELEASE: begin
            dec_ok   = read_open_ff && (rd_frame_ff == frame_ff);
            dec_act  = dec_ok;
            dec_pick = read_slot_ff;
         end
         default: begin
            dec_ok = 1'b0;
         end
      endcase
   end

   // bookkeeping at the decision, slot writes during the update pass
   always_comb begin
      build_open_in = build_open_ff;
      build_slot_in = build_slot_ff;
      read_open_in  = read_open_ff;
      read_slot_in  = read_slot_ff;
      slot_state_in = slot_state_ff;
      slot_frame_in = slot_frame_ff;
      if (cmd.decide && dec_act) begin
         case (mode_ff)
            MODE_BUILD: begin
               build_open_in = 1'b1;
               build_slot_in = dec_pick;
            end
            MODE_PUBLISH: begin
               build_open_in = 1'b0;
            end
            MODE_ACQUIRE: begin
               read_open_in = 1'b1;
               read_slot_in = dec_pick;
            end
            MODE_RELEASE: begin
               read_open_in = 1'b0;
            end
            default: begin
               build_open_in = build_open_ff;
            end
         endcase
      end
      if (cmd.update_en && dec_act_ff) begin
         case (mode_ff)
            MODE_BUILD: begin
               if (hit) begin
                  slot_state_in[ptr] = SLOT_BUILDING;
                  slot_frame_in[ptr] = '0;
               end
            end
            MODE_PUBLISH: begin
               if (hit) begin
                  slot_state_in[ptr] = SLOT_PUBLISHED;
                  slot_frame_in[ptr] = frame_ff;
               end else if (cur_state == SLOT_PUBLISHED && cur_frame < frame_ff) begin
                  slot_state_in[ptr] = SLOT_FREE;
                  slot_frame_in[ptr] = '0;
               end
            end
            MODE_ACQUIRE: begin
               if (hit) begin
                  slot_state_in[ptr] = SLOT_READING;
               end else if (cur_state == SLOT_PUBLISHED) begin
                  slot_state_in[ptr] = SLOT_FREE;
                  slot_frame_in[ptr] = '0;
               end
            end
            MODE_RELEASE: begin
               if (hit) begin
                  slot_state_in[ptr] = SLOT_FREE;
                  slot_frame_in[ptr] = '0;
               end
            end
            default: begin
               slot_state_in[ptr] = cur_state;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         build_open_ff <= 1'b0;
         build_slot_ff <= '0;
         read_open_ff  <= 1'b0;
         read_slot_ff  <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
            slot_frame_ff[i] <= '0;
         end
      end else begin
         build_open_ff <= build_open_in;
         build_slot_ff <= build_slot_in;
         read_open_ff  <= read_open_in;
         read_slot_ff  <= read_slot_in;
         slot_state_ff <= slot_state_in;
         slot_frame_ff <= slot_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      frame_ff      <= frame_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      pub_found_ff  <= pub_found_in;
      pub_idx_ff    <= pub_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_frame_ff <= best_frame_in;
      rd_frame_ff   <= rd_frame_in;
      if (cmd.decide) begin
         dec_ok_ff    <= dec_ok;
         dec_act_ff   <= dec_act;
         dec_pick_ff  <= dec_pick;
         dec_slot_ff  <= dec_slot;
         dec_frame_ff <= dec_frame;
      end
      if (cmd.load_out) begin
         out_ok_ff    <= dec_ok_ff;
         out_slot_ff  <= dec_slot_ff;
         out_frame_ff <= dec_frame_ff;
      end
   end

endmodule

// ----- sv/latest_frame_slot_manager_top.sv -----
`timescale 1ns / 1ps
// Latest-frame slot manager: one producer and one consumer share SLOT_COUNT
// frame-buffer slots. Each request beat on the req_ channel carries a kind in
// req_tuser (begin build, publish, acquire latest, release) and a slot index
// and frame number in req_tdata. Every request yields exactly one response
// beat on the rsp_ channel: rsp_tuser is the ok flag, rsp_tdata the granted
// slot and, for acquire, its frame number (zero where not applicable).
// A request is handled by scanning the slots one per cycle to gather
// candidates, a decision step, then a second pass writing one slot per
// cycle. A new request is taken only after the previous one has finished
// its update pass; the slot scan and the single slot write port set the
// pace.
// The response sits in an output register, so the next request is accepted
// while a response waits; if the receiver stalls longer, the following
// result is parked and the block takes no new request until the waiting
// beat is taken. Reset frees every slot, zeroes every frame number, closes
// any open build or read and drops a pending response.
module latest_frame_slot_manager_top #(
   parameter int SLOT_COUNT = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // slot_index [1:0], frame_id [65:2], zero pad [71:66]
   input  logic [lfsm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // mode [1:0]
   input  logic [lfsm_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // slot_index_res [1:0], frame_id_res [65:2], zero pad [71:66]
   output logic [lfsm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // ok [0]
   output logic [lfsm_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import lfsm_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   dp_cmd_type           cmd;
   logic [IDX_W-1:0]     ptr;
   req_mode_type         req_mode;
   logic [SLOT_W-1:0]    req_slot;
   logic [FRAME_W-1:0]   req_frame;
   logic                 rsp_ok;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [FRAME_W-1:0]   rsp_frame;

   assign req_mode  = req_mode_type'(req_tuser[MODE_W-1:0]);
   assign req_slot  = req_tdata[SLOT_W-1:0];
   assign req_frame = req_tdata[SLOT_W +: FRAME_W];

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_frame, rsp_slot};
   assign rsp_tuser = rsp_ok;

   lfsm_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .cmd       (cmd),
      .ptr       (ptr)
   );

   lfsm_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ptr       (ptr),
      .req_mode  (req_mode),
      .req_slot  (req_slot),
      .req_frame (req_frame),
      .rsp_ok    (rsp_ok),
      .rsp_slot  (rsp_slot),
      .rsp_frame (rsp_frame)
   );

endmodule

// ----- sv/lfsm_checker.sv -----
`timescale 1ns / 1ps
module lfsm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [lfsm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [lfsm_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // a refused request never reports a slot or frame
   refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("refused response carries nonzero data");

   // one request at a time: the scan starts right after acceptance
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one is in work");

   // a fresh response only appears at the end of the work on a request
   rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared without a request in work");

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

endmodule

bind latest_frame_slot_manager_top lfsm_checker u_lfsm_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import lfsm_pkg::*;

   localparam int NUM_SLOTS    = 3;
   localparam int LATENCY      = 2*NUM_SLOTS + 2;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 520;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

   typedef struct packed {
      logic               ok;
      logic [SLOT_W-1:0]  slot;
      logic [FRAME_W-1:0] frame;
   } grant_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // mirror of the slot pool
   slot_state_type     mb_state [NUM_SLOTS] = '{default: SLOT_FREE};
   logic [FRAME_W-1:0] mb_frame [NUM_SLOTS] = '{default: '0};
   logic               mb_build_open = 1'b0;
   logic [SLOT_W-1:0]  mb_build_slot = '0;
   logic               mb_read_open  = 1'b0;
   logic [SLOT_W-1:0]  mb_read_slot  = '0;

   grant_type          expected_grants [$];
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 hold_cycles    = 0;
   int                 hold_left      = 0;
   int                 err_count      = 0;
   int                 quiet_cycles   = 0;
   int                 granted_count  = 0;
   int                 sent_by_mode [4] = '{default: 0};
   logic [FRAME_W-1:0] frame_high = '0;

   latest_frame_slot_manager_top #(.SLOT_COUNT(NUM_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic void mailbox_free(int s);
      mb_state[s] = SLOT_FREE;
      mb_frame[s] = '0;
   endfunction

   function automatic grant_type mailbox_predict(req_mode_type mode, logic [SLOT_W-1:0] idx,
                                                 logic [FRAME_W-1:0] frame);
      grant_type g;
      int        pick;
      int        s;
      g    = '0;
      pick = -1;
      case (mode)
         MODE_BUILD: begin
            if (!mb_build_open) begin
               for (s = 0; s < NUM_SLOTS && pick < 0; s++)
                  if (mb_state[s] == SLOT_FREE) pick = s;
               // no free slot: reclaim the lowest published one
               for (s = 0; s < NUM_SLOTS && pick < 0; s++)
                  if (mb_state[s] == SLOT_PUBLISHED) pick = s;
            end
            if (pick >= 0) begin
               mailbox_free(pick);
               mb_state[pick] = SLOT_BUILDING;
               mb_build_open  = 1'b1;
               mb_build_slot  = pick[SLOT_W-1:0];
               g.ok   = 1'b1;
               g.slot = pick[SLOT_W-1:0];
            end
         end
         MODE_PUBLISH: begin
            if (idx < NUM_SLOTS && mb_build_open && mb_build_slot == idx &&
                mb_state[idx] == SLOT_BUILDING) begin
               mb_frame[idx] = frame;
               mb_state[idx] = SLOT_PUBLISHED;
               mb_build_open = 1'b0;
               for (s = 0; s < NUM_SLOTS; s++)
                  if (s != idx && mb_state[s] == SLOT_PUBLISHED && mb_frame[s] < frame)
                     mailbox_free(s);
               g.ok = 1'b1;
            end
         end
         MODE_ACQUIRE: begin
            if (mb_read_open && mb_state[mb_read_slot] == SLOT_READING) begin
               g.ok    = 1'b1;
               g.slot  = mb_read_slot;
               g.frame = mb_frame[mb_read_slot];
            end else begin
               // strict compare keeps the lowest index on ties
               for (s = 0; s < NUM_SLOTS; s++)
                  if (mb_state[s] == SLOT_PUBLISHED &&
                      (pick < 0 || mb_frame[s] > mb_frame[pick]))
                     pick = s;
               if (pick >= 0) begin
                  for (s = 0; s < NUM_SLOTS; s++)
                     if (s != pick && mb_state[s] == SLOT_PUBLISHED) mailbox_free(s);
                  mb_state[pick] = SLOT_READING;
                  mb_read_open   = 1'b1;
                  mb_read_slot   = pick[SLOT_W-1:0];
                  g.ok    = 1'b1;
                  g.slot  = pick[SLOT_W-1:0];
                  g.frame = mb_frame[pick];
               end
            end
         end
         default: begin
            if (mb_read_open && mb_frame[mb_read_slot] == frame) begin
               mailbox_free(mb_read_slot);
               mb_read_open = 1'b0;
               g.ok = 1'b1;
            end
         end
      endcase
      return g;
   endfunction

   task automatic send_req(input req_mode_type mode, input logic [SLOT_W-1:0] idx,
                           input logic [FRAME_W-1:0] frame);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, frame, idx};
      do @(posedge clock); while (!req_tready);
      expected_grants.push_back(mailbox_predict(mode, idx, frame));
      sent_by_mode[mode]++;
   endtask

   // mostly well-formed producer/consumer traffic, some noise
   task automatic send_random_item();
      int                 pick;
      logic [SLOT_W-1:0]  idx;
      logic [FRAME_W-1:0] frame;
      pick  = $urandom_range(99);
      idx   = SLOT_W'($urandom_range(3));
      frame = {$urandom, $urandom};
      if (pick < 25) begin
         send_req(MODE_BUILD, idx, frame);
      end else if (pick < 50) begin
         if (mb_build_open && $urandom_range(9) != 0) idx = mb_build_slot;
         case ($urandom_range(5))
            0, 1: begin
               frame_high = frame_high + FRAME_W'($urandom_range(1, 4));
               frame      = frame_high;
            end
            2: frame = frame_high;
            3: frame = FRAME_W'($urandom_range(20));
            default: frame_high = frame;
         endcase
         send_req(MODE_PUBLISH, idx, frame);
      end else if (pick < 72) begin
         send_req(MODE_ACQUIRE, idx, frame);
      end else if (pick < 90) begin
         if (mb_read_open && $urandom_range(9) != 0) frame = mb_frame[mb_read_slot];
         send_req(MODE_RELEASE, idx, frame);
      end else begin
         send_req(req_mode_type'(MODE_W'($urandom_range(3))), idx, frame);
      end
   endtask

   task automatic idle_until_drained();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic test_empty_pool();
      send_req(MODE_ACQUIRE, 2'd0, '0);
      send_req(MODE_RELEASE, 2'd0, '0);
      send_req(MODE_PUBLISH, 2'd0, 64'd7);
   endtask

   task automatic test_build_and_publish();
      send_req(MODE_BUILD,   2'd0, '0);
      send_req(MODE_BUILD,   2'd0, '0);       // build already open
      send_req(MODE_PUBLISH, 2'd1, 64'd1);    // not the build slot
      send_req(MODE_PUBLISH, 2'd3, 64'd1);    // index past the pool
      send_req(MODE_PUBLISH, 2'd0, FRAME_MAX);
      send_req(MODE_BUILD,   2'd0, '0);
      send_req(MODE_PUBLISH, 2'd1, '0);       // older than slot 0, both kept
      send_req(MODE_BUILD,   2'd0, '0);
      send_req(MODE_PUBLISH, 2'd2, FRAME_MAX); // equal keeps slot 0, frees slot 1
   endtask

   task automatic test_latest_and_release();
      send_req(MODE_ACQUIRE, 2'd0, '0);       // tie goes to slot 0
      send_req(MODE_ACQUIRE, 2'd3, '0);       // same slot again
      send_req(MODE_RELEASE, 2'd0, '0);       // wrong frame
      send_req(MODE_RELEASE, 2'd0, FRAME_MAX);
      send_req(MODE_ACQUIRE, 2'd0, '0);       // nothing published
   endtask

   task automatic test_reclaim_when_full();
      send_req(MODE_BUILD,   2'd0, '0);
      send_req(MODE_PUBLISH, 2'd0, 64'd10);
      send_req(MODE_ACQUIRE, 2'd0, '0);
      send_req(MODE_BUILD,   2'd0, '0);
      send_req(MODE_PUBLISH, 2'd1, 64'd20);
      send_req(MODE_BUILD,   2'd0, '0);
      send_req(MODE_PUBLISH, 2'd2, 64'd20);
      send_req(MODE_BUILD,   2'd0, '0);       // pool full, reclaims slot 1
      send_req(MODE_PUBLISH, 2'd1, 64'd3);
      send_req(MODE_RELEASE, 2'd0, 64'd10);
   endtask

   task automatic test_random_traffic();
      int idle_mix [4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{35, 35}};
      int phase;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_mix[phase][0];
         recv_stall_pct = idle_mix[phase][1];
         repeat (RANDOM_ITEMS/4) send_random_item();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   // receiver blocks for a long stretch while requests keep coming
   task automatic test_backpressure();
      hold_cycles = HOLD_CYCLES;
      repeat (16) send_random_item();
      idle_until_drained();
   endtask

   always @(posedge clock) begin
      grant_type want;
      grant_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok    = rsp_tuser[0];
         got.slot  = rsp_tdata[SLOT_W-1:0];
         got.frame = rsp_tdata[SLOT_W +: FRAME_W];
         if (expected_grants.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("unexpected beat: ok=%0d slot=%0d frame=%h",
                        got.ok, got.slot, got.frame);
         end else begin
            want = expected_grants.pop_front();
            if (got.ok !== want.ok || got.slot !== want.slot || got.frame !== want.frame) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display({"mismatch: expected ok=%0d slot=%0d frame=%h, ",
                            "got ok=%0d slot=%0d frame=%h"},
                           want.ok, want.slot, want.frame, got.ok, got.slot, got.frame);
            end
            if (want.ok) granted_count++;
         end
      end
   end

   // receiver: random stalls, or one long hold counted here
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_left   = hold_cycles;
         hold_cycles = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_pool();
      test_build_and_publish();
      test_latest_and_release();
      test_reclaim_when_full();
      test_random_traffic();
      test_backpressure();
      idle_until_drained();
      $display("covered %0d requests: %0d build, %0d publish, %0d acquire, %0d release",
               sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3],
               sent_by_mode[0], sent_by_mode[1], sent_by_mode[2], sent_by_mode[3]);
      $display("%0d granted; idle mixes: none, sender gaps, receiver stalls, both; %s",
               granted_count, "plus one long receiver hold");
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors", err_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
